FILE: rtl/mtok_pkg.sv
// mtok_pkg: token kinds, error codes and lexer modes for manifest_tokenizer.
// No dependencies.
package mtok_pkg;

    // line counter width; the line field carries the low 20 bits
    localparam int LINE_BITS = 20;

    typedef enum logic [3:0] {
        TK_EOF = 4'd0, TK_NEWLINE = 4'd1, TK_EQUALS = 4'd2, TK_LBRACKET = 4'd3,
        TK_RBRACKET = 4'd4, TK_COMMA = 4'd5, TK_STRING = 4'd6, TK_INTEGER = 4'd7,
        TK_IDENT = 4'd8, TK_INVALID = 4'd9, TK_TEXT = 4'd10
    } t_tok;

    typedef enum logic [3:0] {
        ER_NONE = 4'd0, ER_SQUOTE = 4'd1, ER_BADCHAR = 4'd2, ER_EOF_STR = 4'd3,
        ER_EOL_STR = 4'd4, ER_BS_EOL = 4'd5, ER_BAD_ESC = 4'd6,
        ER_NOT_DEC = 4'd7, ER_OVERFLOW = 4'd8
    } t_err;

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_STRING, M_ESC, M_SIGN, M_INT, M_BADINT
    } t_mode;

    typedef struct packed {
        t_tok        kind;
        logic        use_start;  // line from r_start, else current line
        logic [7:0]  tb;
        t_err        err;
        logic        is_num;     // number field carries the integer value
    } t_res;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [63:0] TOP_MAG  = 64'h8000_0000_0000_0000;

endpackage

FILE: rtl/manifest_tokenizer.sv
// manifest_tokenizer: streaming lexer for TOML-like manifest text.
// Depends on mtok_pkg.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------
//  input   | in        | i_kind, i_byte_req
//  output  | out       | o_token_kind, o_line, o_number, o_text_byte,
//          |           | o_error_code, o_last
//
// A byte is lexed in the cycle it is accepted: the lexer state and up to
// three results are registered at once. One transfer per cycle is taken
// while the result queue is empty or its last result is being taken; a
// byte that yields several results holds further bytes until the single
// output port has drained them. i_stall holds the queue. Reset (synchronous,
// active low) gives mode idle and line 1.
module manifest_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_byte_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [19:0] o_line,
    output logic [63:0] o_number,
    output logic [7:0]  o_text_byte,
    output logic [3:0]  o_error_code,
    output logic        o_last
);
    localparam int LINE_BITS = mtok_pkg::LINE_BITS;
    localparam logic [LINE_BITS-1:0] MAXL = '1;

    mtok_pkg::t_mode        r_mode, n_mode;
    logic [LINE_BITS-1:0]   r_line, n_line, r_start, n_start;
    logic [63:0]            r_mag, n_mag;
    logic                   r_neg, n_neg, r_ovf, n_ovf, r_hsign, n_hsign;

    // result queue: three slots, each a result plus its line and number
    mtok_pkg::t_res r_q [3];
    logic [19:0]    r_ql [3];
    logic [63:0]    r_qn [3];
    logic [1:0]     r_cnt, r_head;

    mtok_pkg::t_res  e_r [3];
    logic [1:0]      e_n;
    logic [63:0]     num_v;
    logic            fire, pop;
    logic            is_dig, is_id;
    logic [7:0]      c;
    logic [3:0]      dig;
    logic [67:0]     mul10;

    assign c      = i_byte_req;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign is_id  = is_dig || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                  || c == 8'h5F || c == mtok_pkg::CH_MINUS;
    assign dig    = c[3:0];
    assign mul10  = {4'd0, r_mag} * 68'd10;

    assign pop     = o_valid && !i_stall;
    assign o_stall = (r_cnt != 2'd0) && !(r_cnt == 2'd1 && pop);
    assign fire    = i_valid && !o_stall;
    assign o_valid = r_cnt != 2'd0;

    // lexer: pushes results into e_r, updates state
    always_comb begin
        mtok_pkg::t_res rr;
        logic go_idle;   // byte is re-lexed in idle
        logic start_i;   // an integer starts with this digit
        logic st_neg;
        logic [63:0] base_mag;
        logic base_ovf;
        logic add_d;
        n_mode = r_mode; n_line = r_line; n_start = r_start;
        n_mag = r_mag; n_neg = r_neg; n_ovf = r_ovf; n_hsign = r_hsign;
        e_n = 2'd0;
        for (int k = 0; k < 3; k++) e_r[k] = '0;
        go_idle = 1'b0; start_i = 1'b0; st_neg = 1'b0; add_d = 1'b0;
        num_v = r_neg ? (64'd0 - r_mag) : r_mag;
        rr = '0;
        if (i_kind) begin
            unique case (r_mode)
                mtok_pkg::M_IDENT: begin
                    rr.kind = mtok_pkg::TK_IDENT; rr.use_start = 1'b1;
                    e_r[e_n] = rr; e_n = e_n + 2'd1;
                end
                mtok_pkg::M_STRING, mtok_pkg::M_ESC: begin
                    rr.kind = mtok_pkg::TK_INVALID; rr.use_start = 1'b1;
                    rr.err = (r_mode == mtok_pkg::M_STRING) ? mtok_pkg::ER_EOF_STR
                                                            : mtok_pkg::ER_BS_EOL;
                    e_r[e_n] = rr; e_n = e_n + 2'd1;
                end
                mtok_pkg::M_SIGN: begin
                    rr.use_start = 1'b1;
                    if (r_hsign) begin
                        rr.kind = mtok_pkg::TK_TEXT; rr.tb = mtok_pkg::CH_MINUS;
                        e_r[0] = rr;
                        rr.kind = mtok_pkg::TK_IDENT; rr.tb = '0;
                        e_r[1] = rr; e_n = 2'd2;
                    end else begin
                        rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_BADCHAR;
                        e_r[0] = rr; e_n = 2'd1;
                    end
                end
                mtok_pkg::M_INT: begin
                    rr.use_start = 1'b1;
                    if (r_ovf || (!r_neg && r_mag[63])) begin
                        rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_OVERFLOW;
                    end else begin
                        rr.kind = mtok_pkg::TK_INTEGER; rr.is_num = 1'b1;
                    end
                    e_r[0] = rr; e_n = 2'd1;
                end
                mtok_pkg::M_BADINT: begin
                    rr.kind = mtok_pkg::TK_INVALID; rr.use_start = 1'b1;
                    rr.err = mtok_pkg::ER_NOT_DEC;
                    e_r[0] = rr; e_n = 2'd1;
                end
                default: ;
            endcase
            rr = '0; rr.kind = mtok_pkg::TK_EOF;
            e_r[e_n] = rr; e_n = e_n + 2'd1;
            n_mode = mtok_pkg::M_IDLE; n_mag = '0; n_neg = 1'b0;
            n_ovf = 1'b0; n_hsign = 1'b0;
        end else begin
            unique case (r_mode)
                mtok_pkg::M_COMMENT: if (c == mtok_pkg::CH_NL) go_idle = 1'b1;
                mtok_pkg::M_IDENT: begin
                    rr.use_start = 1'b1;
                    if (is_id) begin
                        rr.kind = mtok_pkg::TK_TEXT; rr.tb = c;
                    end else begin
                        rr.kind = mtok_pkg::TK_IDENT; go_idle = 1'b1;
                    end
                    e_r[0] = rr; e_n = 2'd1;
                end
                mtok_pkg::M_STRING: begin
                    rr.use_start = 1'b1;
                    if (c == mtok_pkg::CH_NL) begin
                        rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_EOL_STR;
                        e_r[0] = rr; e_n = 2'd1; go_idle = 1'b1;
                    end else if (c == mtok_pkg::CH_DQUOTE) begin
                        rr.kind = mtok_pkg::TK_STRING; e_r[0] = rr; e_n = 2'd1;
                        n_mode = mtok_pkg::M_IDLE;
                    end else if (c == mtok_pkg::CH_BSLASH) begin
                        n_mode = mtok_pkg::M_ESC;
                    end else begin
                        rr.kind = mtok_pkg::TK_TEXT; rr.tb = c; e_r[0] = rr; e_n = 2'd1;
                    end
                end
                mtok_pkg::M_ESC: begin
                    rr.use_start = 1'b1; rr.kind = mtok_pkg::TK_TEXT;
                    n_mode = mtok_pkg::M_STRING;
                    case (c)
                        mtok_pkg::CH_NL: begin
                            rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_BS_EOL;
                            go_idle = 1'b1;
                        end
                        mtok_pkg::CH_DQUOTE, mtok_pkg::CH_BSLASH: rr.tb = c;
                        8'h6E: rr.tb = 8'd10;
                        8'h74: rr.tb = 8'd9;
                        8'h72: rr.tb = 8'd13;
                        default: begin
                            rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_BAD_ESC;
                            rr.use_start = 1'b0; n_mode = mtok_pkg::M_IDLE;
                        end
                    endcase
                    e_r[0] = rr; e_n = 2'd1;
                end
                mtok_pkg::M_SIGN: begin
                    rr.use_start = 1'b1;
                    if (is_dig) begin
                        start_i = 1'b1; st_neg = r_hsign;
                    end else if (r_hsign) begin
                        rr.kind = mtok_pkg::TK_TEXT; rr.tb = mtok_pkg::CH_MINUS;
                        e_r[0] = rr;
                        if (is_id) begin
                            rr.tb = c; n_mode = mtok_pkg::M_IDENT;
                        end else begin
                            rr.kind = mtok_pkg::TK_IDENT; rr.tb = '0; go_idle = 1'b1;
                        end
                        e_r[1] = rr; e_n = 2'd2;
                    end else begin
                        rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_BADCHAR;
                        e_r[0] = rr; e_n = 2'd1; go_idle = 1'b1;
                    end
                end
                mtok_pkg::M_INT: begin
                    if (is_dig) add_d = 1'b1;
                    else if (is_id) n_mode = mtok_pkg::M_BADINT;
                    else begin
                        rr.use_start = 1'b1;
                        if (r_ovf || (!r_neg && r_mag[63])) begin
                            rr.kind = mtok_pkg::TK_INVALID;
                            rr.err = mtok_pkg::ER_OVERFLOW;
                        end else begin
                            rr.kind = mtok_pkg::TK_INTEGER; rr.is_num = 1'b1;
                        end
                        e_r[0] = rr; e_n = 2'd1; go_idle = 1'b1;
                    end
                end
                mtok_pkg::M_BADINT: begin
                    if (!is_id) begin
                        rr.kind = mtok_pkg::TK_INVALID; rr.use_start = 1'b1;
                        rr.err = mtok_pkg::ER_NOT_DEC;
                        e_r[0] = rr; e_n = 2'd1; go_idle = 1'b1;
                    end
                end
                default: go_idle = 1'b1;
            endcase
            if (go_idle) begin
                n_mode = mtok_pkg::M_IDLE;
                rr = '0;
                case (c)
                    8'h20, 8'h09, 8'h0D: ;
                    mtok_pkg::CH_HASH: n_mode = mtok_pkg::M_COMMENT;
                    mtok_pkg::CH_NL: begin
                        rr.kind = mtok_pkg::TK_NEWLINE;
                        e_r[e_n] = rr; e_n = e_n + 2'd1;
                        if (r_line != MAXL) n_line = r_line + 1'b1;
                    end
                    8'h3D, 8'h5B, 8'h5D, 8'h2C: begin
                        rr.kind = (c == 8'h3D) ? mtok_pkg::TK_EQUALS :
                                  (c == 8'h5B) ? mtok_pkg::TK_LBRACKET :
                                  (c == 8'h5D) ? mtok_pkg::TK_RBRACKET :
                                                 mtok_pkg::TK_COMMA;
                        e_r[e_n] = rr; e_n = e_n + 2'd1;
                    end
                    mtok_pkg::CH_DQUOTE: begin
                        n_start = r_line; n_mode = mtok_pkg::M_STRING;
                    end
                    8'h27: begin
                        rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_SQUOTE;
                        e_r[e_n] = rr; e_n = e_n + 2'd1;
                    end
                    mtok_pkg::CH_MINUS, mtok_pkg::CH_PLUS: begin
                        n_start = r_line; n_hsign = (c == mtok_pkg::CH_MINUS);
                        n_mode = mtok_pkg::M_SIGN;
                    end
                    default: begin
                        if (is_dig) begin
                            n_start = r_line; start_i = 1'b1;
                        end else if (is_id) begin
                            n_start = r_line; n_mode = mtok_pkg::M_IDENT;
                            rr.kind = mtok_pkg::TK_TEXT; rr.tb = c;
                            e_r[e_n] = rr; e_n = e_n + 2'd1;
                        end else begin
                            rr.kind = mtok_pkg::TK_INVALID; rr.err = mtok_pkg::ER_BADCHAR;
                            e_r[e_n] = rr; e_n = e_n + 2'd1;
                        end
                    end
                endcase
            end
            // digit accumulation: fresh start or continuing integer
            base_mag = start_i ? 64'd0 : r_mag;
            base_ovf = start_i ? 1'b0 : r_ovf;
            if (start_i) begin
                n_neg = st_neg; n_mode = mtok_pkg::M_INT;
            end
            if (start_i || add_d) begin
                n_ovf = base_ovf; n_mag = base_mag;
                if (!base_ovf) begin
                    if (start_i) n_mag = {60'd0, dig};
                    else if (mul10[67:64] != 4'd0 ||
                             (mul10[63:0] + {60'd0, dig}) > mtok_pkg::TOP_MAG ||
                             (mul10[63:0] + {60'd0, dig}) < mul10[63:0])
                        n_ovf = 1'b1;
                    else n_mag = mul10[63:0] + {60'd0, dig};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mtok_pkg::M_IDLE; r_line <= LINE_BITS'(1); r_start <= LINE_BITS'(1);
            r_mag <= '0; r_neg <= 1'b0; r_ovf <= 1'b0; r_hsign <= 1'b0;
            r_cnt <= '0; r_head <= '0;
        end else begin
            if (fire) begin
                r_mode <= n_mode; r_line <= n_line; r_start <= n_start;
                r_mag <= n_mag; r_neg <= n_neg; r_ovf <= n_ovf; r_hsign <= n_hsign;
                r_cnt <= e_n; r_head <= '0;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1; r_head <= r_head + 2'd1;
            end
        end
    end

    // queue payload, loaded with all results of one byte
    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k]  <= e_r[k];
                r_ql[k] <= e_r[k].use_start ? 20'(r_start) : 20'(r_line);
                r_qn[k] <= e_r[k].is_num ? num_v : 64'd0;
            end
        end
    end

    assign o_token_kind = r_q[r_head].kind;
    assign o_line       = r_ql[r_head];
    assign o_number     = r_qn[r_head];
    assign o_text_byte  = r_q[r_head].tb;
    assign o_error_code = r_q[r_head].err;
    assign o_last       = (r_cnt == 2'd1);

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> o_stall) else $error("accepted over pending results");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == mtok_pkg::TK_EOF) |-> o_last)
        else $error("eof not last");
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != mtok_pkg::ER_NONE) |->
        (o_token_kind == mtok_pkg::TK_INVALID)) else $error("error on valid token");
endmodule

FILE: verif/manifest_tokenizer_checker.sv
// manifest_tokenizer_checker: watches both channels of manifest_tokenizer,
// predicts its tokens and compares them. Depends on mtok_pkg.
`timescale 1ns / 100ps
module manifest_tokenizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_byte_req,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [3:0]  o_token_kind,
    input  logic [19:0] o_line,
    input  logic [63:0] o_number,
    input  logic [7:0]  o_text_byte,
    input  logic [3:0]  o_error_code,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_token_count
);

    localparam int LINE_BITS = mtok_pkg::LINE_BITS;
    localparam logic [31:0] LINE_MAX = (32'd1 << LINE_BITS) - 32'd1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [19:0] line;
        logic [63:0] number;
        logic [7:0]  tb;
        logic [3:0]  err;
        logic        last;
    } t_token;

    t_token token_q[$];

    // lexer state copy
    mtok_pkg::t_mode lx_mode;
    logic [31:0] lx_line;
    logic [31:0] lx_start;
    logic [63:0] lx_mag;
    logic        lx_neg;
    logic        lx_ovf;
    logic [7:0]  lx_sign;
    t_token      step_tok[$];

    assign o_pending = token_q.size();

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_ident_ch(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == "_" || c == mtok_pkg::CH_MINUS;
    endfunction

    task automatic push_tok(mtok_pkg::t_tok k, logic [31:0] ln, logic [63:0] num,
                            logic [7:0] tb, mtok_pkg::t_err err);
        t_token t;
        t.kind = k;
        t.line = ln[19:0];
        t.number = num;
        t.tb = tb;
        t.err = err;
        t.last = 1'b0;
        if (step_tok.size() < 3) step_tok = {step_tok, t};
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - "0");
        if (lx_ovf) return;
        if (lx_mag > (mtok_pkg::TOP_MAG - d) / 10) lx_ovf = 1'b1;
        else lx_mag = lx_mag * 10 + d;
    endtask

    task automatic start_int(bit neg);
        lx_neg = neg;
        lx_mag = '0;
        lx_ovf = 1'b0;
        lx_mode = mtok_pkg::M_INT;
    endtask

    task automatic close_int();
        if (lx_ovf || (!lx_neg && lx_mag > mtok_pkg::TOP_MAG - 1))
            push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_OVERFLOW);
        else
            push_tok(mtok_pkg::TK_INTEGER, lx_start, lx_neg ? -lx_mag : lx_mag, '0,
                     mtok_pkg::ER_NONE);
    endtask

    task automatic lex_idle(logic [7:0] c);
        case (c)
            " ", 8'h09, 8'h0D: ;
            mtok_pkg::CH_HASH: lx_mode = mtok_pkg::M_COMMENT;
            mtok_pkg::CH_NL: begin
                push_tok(mtok_pkg::TK_NEWLINE, lx_line, '0, '0, mtok_pkg::ER_NONE);
                if (lx_line < LINE_MAX) lx_line++;
            end
            "=": push_tok(mtok_pkg::TK_EQUALS, lx_line, '0, '0, mtok_pkg::ER_NONE);
            "[": push_tok(mtok_pkg::TK_LBRACKET, lx_line, '0, '0, mtok_pkg::ER_NONE);
            "]": push_tok(mtok_pkg::TK_RBRACKET, lx_line, '0, '0, mtok_pkg::ER_NONE);
            ",": push_tok(mtok_pkg::TK_COMMA, lx_line, '0, '0, mtok_pkg::ER_NONE);
            mtok_pkg::CH_DQUOTE: begin
                lx_start = lx_line;
                lx_mode = mtok_pkg::M_STRING;
            end
            8'h27: push_tok(mtok_pkg::TK_INVALID, lx_line, '0, '0, mtok_pkg::ER_SQUOTE);
            mtok_pkg::CH_MINUS, mtok_pkg::CH_PLUS: begin
                lx_start = lx_line;
                lx_sign = c;
                lx_mode = mtok_pkg::M_SIGN;
            end
            default: begin
                if (is_digit(c)) begin
                    lx_start = lx_line;
                    start_int(1'b0);
                    add_digit(c);
                end else if (is_ident_ch(c)) begin
                    lx_start = lx_line;
                    push_tok(mtok_pkg::TK_TEXT, lx_start, '0, c, mtok_pkg::ER_NONE);
                    lx_mode = mtok_pkg::M_IDENT;
                end else begin
                    push_tok(mtok_pkg::TK_INVALID, lx_line, '0, '0, mtok_pkg::ER_BADCHAR);
                end
            end
        endcase
    endtask

    task automatic lex_word(logic [7:0] c);
        if (is_ident_ch(c)) begin
            push_tok(mtok_pkg::TK_TEXT, lx_start, '0, c, mtok_pkg::ER_NONE);
        end else begin
            push_tok(mtok_pkg::TK_IDENT, lx_start, '0, '0, mtok_pkg::ER_NONE);
            lx_mode = mtok_pkg::M_IDLE;
            lex_idle(c);
        end
    endtask

    task automatic lex_byte(logic [7:0] c);
        logic [7:0] dec;
        case (lx_mode)
            mtok_pkg::M_COMMENT: if (c == mtok_pkg::CH_NL) begin
                lx_mode = mtok_pkg::M_IDLE;
                lex_idle(c);
            end
            mtok_pkg::M_IDENT: lex_word(c);
            mtok_pkg::M_STRING: begin
                if (c == mtok_pkg::CH_NL) begin
                    push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_EOL_STR);
                    lx_mode = mtok_pkg::M_IDLE;
                    lex_idle(c);
                end else if (c == mtok_pkg::CH_DQUOTE) begin
                    push_tok(mtok_pkg::TK_STRING, lx_start, '0, '0, mtok_pkg::ER_NONE);
                    lx_mode = mtok_pkg::M_IDLE;
                end else if (c == mtok_pkg::CH_BSLASH) begin
                    lx_mode = mtok_pkg::M_ESC;
                end else begin
                    push_tok(mtok_pkg::TK_TEXT, lx_start, '0, c, mtok_pkg::ER_NONE);
                end
            end
            mtok_pkg::M_ESC: begin
                if (c == mtok_pkg::CH_NL) begin
                    push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_BS_EOL);
                    lx_mode = mtok_pkg::M_IDLE;
                    lex_idle(c);
                end else begin
                    case (c)
                        mtok_pkg::CH_DQUOTE: dec = mtok_pkg::CH_DQUOTE;
                        mtok_pkg::CH_BSLASH: dec = mtok_pkg::CH_BSLASH;
                        "n": dec = 8'd10;
                        "t": dec = 8'd9;
                        "r": dec = 8'd13;
                        default: dec = 8'd0;
                    endcase
                    if (dec == 8'd0) begin
                        push_tok(mtok_pkg::TK_INVALID, lx_line, '0, '0,
                                 mtok_pkg::ER_BAD_ESC);
                        lx_mode = mtok_pkg::M_IDLE;
                    end else begin
                        push_tok(mtok_pkg::TK_TEXT, lx_start, '0, dec, mtok_pkg::ER_NONE);
                        lx_mode = mtok_pkg::M_STRING;
                    end
                end
            end
            mtok_pkg::M_SIGN: begin
                if (is_digit(c)) begin
                    start_int(lx_sign == mtok_pkg::CH_MINUS);
                    add_digit(c);
                end else if (lx_sign == mtok_pkg::CH_MINUS) begin
                    push_tok(mtok_pkg::TK_TEXT, lx_start, '0, mtok_pkg::CH_MINUS,
                             mtok_pkg::ER_NONE);
                    lx_mode = mtok_pkg::M_IDENT;
                    lex_word(c);
                end else begin
                    push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_BADCHAR);
                    lx_mode = mtok_pkg::M_IDLE;
                    lex_idle(c);
                end
            end
            mtok_pkg::M_INT: begin
                if (is_digit(c)) add_digit(c);
                else if (is_ident_ch(c)) lx_mode = mtok_pkg::M_BADINT;
                else begin
                    close_int();
                    lx_mode = mtok_pkg::M_IDLE;
                    lex_idle(c);
                end
            end
            mtok_pkg::M_BADINT: if (!is_ident_ch(c)) begin
                push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_NOT_DEC);
                lx_mode = mtok_pkg::M_IDLE;
                lex_idle(c);
            end
            default: begin
                lx_mode = mtok_pkg::M_IDLE;
                lex_idle(c);
            end
        endcase
    endtask

    task automatic lex_end();
        case (lx_mode)
            mtok_pkg::M_IDENT:
                push_tok(mtok_pkg::TK_IDENT, lx_start, '0, '0, mtok_pkg::ER_NONE);
            mtok_pkg::M_STRING:
                push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_EOF_STR);
            mtok_pkg::M_ESC:
                push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_BS_EOL);
            mtok_pkg::M_SIGN: if (lx_sign == mtok_pkg::CH_MINUS) begin
                push_tok(mtok_pkg::TK_TEXT, lx_start, '0, mtok_pkg::CH_MINUS,
                         mtok_pkg::ER_NONE);
                push_tok(mtok_pkg::TK_IDENT, lx_start, '0, '0, mtok_pkg::ER_NONE);
            end else begin
                push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_BADCHAR);
            end
            mtok_pkg::M_INT: close_int();
            mtok_pkg::M_BADINT:
                push_tok(mtok_pkg::TK_INVALID, lx_start, '0, '0, mtok_pkg::ER_NOT_DEC);
            default: ;
        endcase
        push_tok(mtok_pkg::TK_EOF, lx_line, '0, '0, mtok_pkg::ER_NONE);
        lx_mode = mtok_pkg::M_IDLE;
        lx_mag = '0;
        lx_neg = 1'b0;
        lx_ovf = 1'b0;
        lx_sign = '0;
    endtask

    always @(posedge i_clk) begin
        t_token got, want;
        if (!i_rst_n) begin
            lx_mode = mtok_pkg::M_IDLE;
            lx_line = 1;
            lx_start = 1;
            lx_mag = '0;
            lx_neg = 1'b0;
            lx_ovf = 1'b0;
            lx_sign = '0;
            token_q.delete();
            o_fail_count <= 0;
            o_token_count <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                step_tok.delete();
                if (i_kind) lex_end();
                else lex_byte(i_byte_req);
                if (step_tok.size() > 0) step_tok[step_tok.size() - 1].last = 1'b1;
                foreach (step_tok[k]) token_q = {token_q, step_tok[k]};
            end
            if (o_valid && !i_stall) begin
                got = {o_token_kind, o_line, o_number, o_text_byte, o_error_code, o_last};
                o_token_count <= o_token_count + 1;
                if (token_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t unexpected token kind=%0d line=%0d", $realtime,
                                 o_token_kind, o_line);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = token_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display(
                                "%0t mismatch exp kind=%0d line=%0d num=%0d tb=%h err=%0d",
                                $realtime, want.kind, want.line, $signed(want.number),
                                want.tb, want.err);
                            $display("    exp last=%0b, got kind=%0d line=%0d num=%0d",
                                     want.last, got.kind, got.line, $signed(got.number));
                            $display("    got tb=%h err=%0d last=%0b", got.tb, got.err,
                                     got.last);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb_manifest_tokenizer.sv
// tb_manifest_tokenizer: stimulus and verdict for manifest_tokenizer.
// Depends on mtok_pkg, manifest_tokenizer and manifest_tokenizer_checker.
`timescale 1ns / 100ps
module tb_manifest_tokenizer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_kind;
    logic [7:0]  i_byte_req;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_token_kind;
    logic [19:0] o_line;
    logic [63:0] o_number;
    logic [7:0]  o_text_byte;
    logic [3:0]  o_error_code;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          token_count;

    // idle percentages, in units of one percent
    int send_idle_pct;
    int recv_idle_pct;
    int byte_count;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    manifest_tokenizer u_dut (.*);

    manifest_tokenizer_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_byte_req,
        .o_valid, .i_stall, .o_token_kind, .o_line, .o_number, .o_text_byte,
        .o_error_code, .o_last,
        .o_fail_count(fail_count), .o_pending(pending), .o_token_count(token_count)
    );

    // Receiver stall: random per cycle at the current rate.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // One transfer: optional idle gaps, then hold valid until accepted.
    // Valid is only lowered when the next item is not sent right away.
    task automatic send_item(logic kind, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_byte_req <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        byte_count++;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_item(1'b0, s[k]);
    endtask

    // Random identifier character
    function automatic logic [7:0] ident_char();
        case ($urandom_range(3))
            0: return 8'("a" + $urandom_range(25));
            1: return 8'("A" + $urandom_range(25));
            2: return 8'("0" + $urandom_range(9));
            default: return $urandom_range(1) ? 8'("_") : mtok_pkg::CH_MINUS;
        endcase
    endfunction

    // One random well-formed-ish manifest fragment
    task automatic send_fragment();
        int n;
        case ($urandom_range(9))
            0: begin
                n = $urandom_range(1, 5);
                send_item(1'b0, 8'("a" + $urandom_range(25)));
                repeat (n) send_item(1'b0, ident_char());
                send_text(" = ");
            end
            1: begin
                send_item(1'b0, mtok_pkg::CH_DQUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(5) == 0) begin
                        send_item(1'b0, mtok_pkg::CH_BSLASH);
                        case ($urandom_range(6))
                            0: send_item(1'b0, mtok_pkg::CH_DQUOTE);
                            1: send_item(1'b0, mtok_pkg::CH_BSLASH);
                            2: send_item(1'b0, "n");
                            3: send_item(1'b0, "t");
                            4: send_item(1'b0, "r");
                            5: send_item(1'b0, mtok_pkg::CH_NL);
                            default: send_item(1'b0, 8'($urandom_range(255)));
                        endcase
                    end else begin
                        send_item(1'b0, 8'($urandom_range(32, 126)));
                    end
                end
                if ($urandom_range(7) != 0) send_item(1'b0, mtok_pkg::CH_DQUOTE);
            end
            2: begin
                if ($urandom_range(1))
                    send_item(1'b0, $urandom_range(1) ? mtok_pkg::CH_MINUS
                                                      : mtok_pkg::CH_PLUS);
                n = ($urandom_range(9) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 6);
                repeat (n) send_item(1'b0, 8'("0" + $urandom_range(9)));
                if ($urandom_range(7) == 0) send_item(1'b0, ident_char());
                send_item(1'b0, ",");
            end
            3: send_item(1'b0, mtok_pkg::CH_NL);
            4: send_text("[t]\n");
            5: begin
                send_item(1'b0, mtok_pkg::CH_HASH);
                repeat ($urandom_range(4)) send_item(1'b0, 8'($urandom_range(255)));
                send_item(1'b0, mtok_pkg::CH_NL);
            end
            6: send_item(1'b0, 8'($urandom_range(255)));
            7: send_item(1'b1, 8'($urandom_range(255)));
            default: send_item(1'b0, $urandom_range(1) ? " " : 8'h09);
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_byte_req = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        byte_count = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: punctuation, comment, strings with all escapes, int edges
        send_idle_pct = 12;
        recv_idle_pct = 73;
        send_text("a-1=[],'+x #c\n");
        send_text("\"q\\\"\\\\\\n\\t\\r\\z\"\"e\n");
        send_text("9223372036854775807 -9223372036854775808 9223372036854775808 ");
        send_text("12ab -x + \"s\\");
        send_item(1'b1, 8'hFF);
        send_text("-");
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h01);
        send_item(1'b0, 8'h7F);
        send_item(1'b1, 8'h00);
        drain();

        // Random: three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 12 : 0;
            while (byte_count < 120 + 75 * (ph + 1)) send_fragment();
            send_item(1'b1, 8'h00);
        end
        drain();

        $display("Sent %0d transfers (directed edge cases and random manifest text)",
                 byte_count);
        $display("Checked %0d tokens across three stall/idle patterns", token_count);
        if (fail_count == 0)
            $display("tb_manifest_tokenizer: PASS");
        else
            $display("tb_manifest_tokenizer: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb_manifest_tokenizer: FAIL");
        $finish;
    end

endmodule
